// File: rtl/uoa_pkg.sv
// ----------------------------------------------------------------------------
// uoa_pkg
// Shared types, constants and helpers for the ultrasonic obstacle-avoid block.
// ----------------------------------------------------------------------------
package uoa_pkg;

    localparam int NUM_SENSORS = 3;
    localparam int TIMER_BITS  = 16;

    localparam int CH_W     = 2;
    localparam int STAMP_W  = 16;
    localparam int TIME_W   = 32;
    localparam int RANGE_W  = 11;
    localparam int DIST_W   = 10;
    localparam int SPEED_W  = 10;
    localparam int DWELL_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // echo width to centimetres: divide by 58 via reciprocal multiply
    localparam int ECHO_DIV   = 58;
    localparam int ECHO_SHIFT = TIMER_BITS + 6;
    localparam logic [TIMER_BITS:0] ECHO_RECIP =
        (TIMER_BITS + 1)'(((64'd1 << ECHO_SHIFT) + 64'(ECHO_DIV) - 64'd1) / 64'(ECHO_DIV));

    localparam int RANGE_MAX   = 2047;
    localparam int FAR_CM      = 999;
    localparam int NEAR_CUTOFF = 3;

    // configuration reset values
    localparam logic              RST_AUTO_EN    = 1'b0;
    localparam logic [DIST_W-1:0] RST_DANGER     = DIST_W'(13);
    localparam logic [DIST_W-1:0] RST_RECOVER    = DIST_W'(25);
    localparam logic [DIST_W-1:0] RST_MARGIN     = DIST_W'(15);
    localparam logic [DWELL_W-1:0] RST_ACTION    = DWELL_W'(300);
    localparam logic [SPEED_W-1:0] RST_BASE_SPD  = SPEED_W'(300);
    localparam logic [SPEED_W-1:0] RST_TURN_SPD  = SPEED_W'(300);
    localparam logic [SPEED_W-1:0] RST_BACK_SPD  = SPEED_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_EN   = 3'd0,
        CFG_DANGER    = 3'd1,
        CFG_RECOVER   = 3'd2,
        CFG_MARGIN    = 3'd3,
        CFG_ACTION    = 3'd4,
        CFG_BASE_SPD  = 3'd5,
        CFG_TURN_SPD  = 3'd6,
        CFG_BACK_SPD  = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_STEP    = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        NAV_FWD   = 2'd0,
        NAV_BACK  = 2'd1,
        NAV_LEFT  = 2'd2,
        NAV_RIGHT = 2'd3
    } nav_state_t;

    typedef enum logic [1:0] {
        DIR_HALT = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } motor_dir_t;

    typedef logic [NUM_SENSORS-1:0][RANGE_W-1:0] range_arr_t;

    typedef struct packed {
        logic                opcode;
        logic [CH_W-1:0]     sensor_channel;
        logic [STAMP_W-1:0]  capture_stamp;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic                drive_valid;
        logic [1:0]          nav_state_out;
        logic [SPEED_W-1:0]  motor_a_speed;
        logic [1:0]          motor_a_dir;
        logic [SPEED_W-1:0]  motor_b_speed;
        logic [1:0]          motor_b_dir;
        logic [RANGE_W-1:0]  front_range;
        logic [RANGE_W-1:0]  left_range;
        logic [RANGE_W-1:0]  right_range;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0]  danger_lim;
        logic [DIST_W-1:0]  clear_lim;
        logic [DIST_W-1:0]  side_margin;
        logic [DWELL_W-1:0] action_time_ms;
        logic [SPEED_W-1:0] fwd_spd;
        logic [SPEED_W-1:0] spin_spd;
        logic [SPEED_W-1:0] rev_spd;
    } nav_cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] a_speed;
        motor_dir_t         a_dir;
        logic [SPEED_W-1:0] b_speed;
        motor_dir_t         b_dir;
    } motor_cmd_t;

    // pulse width in timer ticks to centimetres, saturated to the range field
    function automatic logic [RANGE_W-1:0] echo_to_cm(input logic [TIMER_BITS-1:0] w);
        logic [2*TIMER_BITS:0] prod;
        logic [TIMER_BITS-1:0] quo;
        prod = {{(TIMER_BITS + 1){1'b0}}, w} * {{TIMER_BITS{1'b0}}, ECHO_RECIP};
        quo  = TIMER_BITS'(prod >> ECHO_SHIFT);
        if (64'(quo) > 64'(RANGE_MAX))
            return RANGE_W'(RANGE_MAX);
        return RANGE_W'(quo);
    endfunction

    // very short echoes are treated as nothing in sight
    function automatic logic [RANGE_W-1:0] sanitize(input logic [RANGE_W-1:0] d);
        if (d <= RANGE_W'(NEAR_CUTOFF))
            return RANGE_W'(FAR_CM);
        return d;
    endfunction

endpackage

// File: rtl/uoa_echo.sv
// ----------------------------------------------------------------------------
// uoa_echo
// Per-sensor echo edge pairing and width-to-distance conversion.
// ----------------------------------------------------------------------------
module uoa_echo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capture_en,
    input  logic [uoa_pkg::CH_W-1:0]      channel,
    input  logic [uoa_pkg::STAMP_W-1:0]   stamp,
    output uoa_pkg::range_arr_t           range_cur,
    output uoa_pkg::range_arr_t           range_next
);

    logic [uoa_pkg::NUM_SENSORS-1:0]                          pend_reg, pend_next;
    logic [uoa_pkg::NUM_SENSORS-1:0][uoa_pkg::TIMER_BITS-1:0] rise_reg, rise_next;
    uoa_pkg::range_arr_t                                      range_reg;

    logic [uoa_pkg::TIMER_BITS-1:0] fall;
    logic [uoa_pkg::TIMER_BITS-1:0] width;
    logic [uoa_pkg::TIMER_BITS-1:0] rise_sel;
    logic [uoa_pkg::RANGE_W-1:0]    echo_cm;

    assign fall = uoa_pkg::TIMER_BITS'(stamp);

    always_comb
    begin
        rise_sel = '0;
        for (int i = 0; i < uoa_pkg::NUM_SENSORS; i++)
        begin
            if (channel == uoa_pkg::CH_W'(i))
                rise_sel = rise_reg[i];
        end
    end

    // fall not after rise wraps through the timer maximum: equal stamps give all ones
    assign width   = (fall > rise_sel) ? (fall - rise_sel) : (fall - rise_sel - 1'b1);
    assign echo_cm = uoa_pkg::echo_to_cm(width);

    always_comb
    begin
        pend_next  = pend_reg;
        rise_next  = rise_reg;
        range_next = range_reg;
        for (int i = 0; i < uoa_pkg::NUM_SENSORS; i++)
        begin
            if (capture_en && channel == uoa_pkg::CH_W'(i))
            begin
                if (!pend_reg[i])
                begin
                    rise_next[i] = fall;
                    pend_next[i] = 1'b1;
                end
                else
                begin
                    range_next[i] = echo_cm;
                    pend_next[i]  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            rise_reg  <= '0;
            range_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            rise_reg  <= rise_next;
            range_reg <= range_next;
        end
    end

    assign range_cur = range_reg;

endmodule

// File: rtl/uoa_nav.sv
// ----------------------------------------------------------------------------
// uoa_nav
// Forward / back / turn navigation state machine with dwell timer.
// ----------------------------------------------------------------------------
module uoa_nav (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic [uoa_pkg::TIME_W-1:0]   now_ms,
    input  uoa_pkg::range_arr_t          ranges,
    input  uoa_pkg::nav_cfg_t            cfg,
    output uoa_pkg::motor_cmd_t          cmd,
    output uoa_pkg::nav_state_t          state_after
);

    uoa_pkg::nav_state_t            nav_state_reg, nav_state_next;
    logic [uoa_pkg::TIME_W-1:0]     start_reg, start_next;

    logic [uoa_pkg::RANGE_W-1:0]    fd, ld, rd;
    logic [uoa_pkg::RANGE_W-1:0]    danger, recover;
    logic [uoa_pkg::RANGE_W:0]      ld_plus, rd_plus;
    logic [uoa_pkg::TIME_W-1:0]     elapsed;
    logic                           dwell_done;
    logic                           f_danger, l_danger, r_danger, f_clear;

    assign fd = uoa_pkg::sanitize(ranges[0]);
    assign ld = uoa_pkg::sanitize(ranges[1]);
    assign rd = uoa_pkg::sanitize(ranges[2]);

    assign danger  = uoa_pkg::RANGE_W'(cfg.danger_lim);
    assign recover = uoa_pkg::RANGE_W'(cfg.clear_lim);
    assign ld_plus = (uoa_pkg::RANGE_W + 1)'(ld) + (uoa_pkg::RANGE_W + 1)'(cfg.side_margin);
    assign rd_plus = (uoa_pkg::RANGE_W + 1)'(rd) + (uoa_pkg::RANGE_W + 1)'(cfg.side_margin);

    assign elapsed    = now_ms - start_reg;
    assign dwell_done = elapsed >= uoa_pkg::TIME_W'(cfg.action_time_ms);

    assign f_danger = fd <= danger;
    assign l_danger = ld <= danger;
    assign r_danger = rd <= danger;
    assign f_clear  = fd >= recover;

    always_comb
    begin
        nav_state_next = nav_state_reg;
        start_next     = start_reg;
        cmd            = '{a_speed: '0, a_dir: uoa_pkg::DIR_HALT,
                           b_speed: '0, b_dir: uoa_pkg::DIR_HALT};
        if (step_en)
        begin
            case (nav_state_reg)
                uoa_pkg::NAV_FWD:
                begin
                    cmd = '{a_speed: cfg.fwd_spd, a_dir: uoa_pkg::DIR_FWD,
                            b_speed: cfg.fwd_spd, b_dir: uoa_pkg::DIR_FWD};
                    if (f_danger)
                    begin
                        nav_state_next = uoa_pkg::NAV_BACK;
                        start_next     = now_ms;
                    end
                    else if (l_danger)
                    begin
                        nav_state_next = uoa_pkg::NAV_RIGHT;
                        start_next     = now_ms;
                    end
                    else if (r_danger)
                    begin
                        nav_state_next = uoa_pkg::NAV_LEFT;
                        start_next     = now_ms;
                    end
                    else if (f_clear && (uoa_pkg::RANGE_W + 1)'(rd) > ld_plus)
                    begin
                        nav_state_next = uoa_pkg::NAV_RIGHT;
                        start_next     = now_ms;
                    end
                    else if (f_clear && (uoa_pkg::RANGE_W + 1)'(ld) > rd_plus)
                    begin
                        nav_state_next = uoa_pkg::NAV_LEFT;
                        start_next     = now_ms;
                    end
                end
                uoa_pkg::NAV_BACK:
                begin
                    if (dwell_done)
                    begin
                        // stop for one step, pick the way out, restart the dwell
                        start_next = now_ms;
                        if (fd > recover)
                            nav_state_next = uoa_pkg::NAV_FWD;
                        else if (ld > rd)
                            nav_state_next = uoa_pkg::NAV_LEFT;
                        else
                            nav_state_next = uoa_pkg::NAV_RIGHT;
                    end
                    else
                    begin
                        cmd = '{a_speed: cfg.rev_spd, a_dir: uoa_pkg::DIR_BACK,
                                b_speed: cfg.rev_spd, b_dir: uoa_pkg::DIR_BACK};
                    end
                end
                uoa_pkg::NAV_LEFT:
                begin
                    cmd = '{a_speed: cfg.spin_spd, a_dir: uoa_pkg::DIR_BACK,
                            b_speed: cfg.spin_spd, b_dir: uoa_pkg::DIR_FWD};
                    if (f_danger)
                    begin
                        if (dwell_done)
                            nav_state_next = uoa_pkg::NAV_FWD;
                    end
                    else if (rd >= recover && f_clear)
                        nav_state_next = uoa_pkg::NAV_FWD;
                end
                default:
                begin
                    cmd = '{a_speed: cfg.spin_spd, a_dir: uoa_pkg::DIR_FWD,
                            b_speed: cfg.spin_spd, b_dir: uoa_pkg::DIR_BACK};
                    if (f_danger)
                    begin
                        if (dwell_done)
                            nav_state_next = uoa_pkg::NAV_FWD;
                    end
                    else if (ld >= recover && f_clear)
                        nav_state_next = uoa_pkg::NAV_FWD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_state_reg <= uoa_pkg::NAV_FWD;
            start_reg     <= '0;
        end
        else
        begin
            nav_state_reg <= nav_state_next;
            start_reg     <= start_next;
        end
    end

    assign state_after = nav_state_next;

endmodule

// File: rtl/ultrasonic_obstacle_avoid_fsm.sv
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_avoid_fsm
// Echo ranging for three sensors and an obstacle-avoiding drive controller.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. opcode selects a capture
//                    edge (sensor_channel, capture_stamp) or a control step
//                    (now_ms). Every word in gives exactly one result word.
//   result channel : result_valid / result_stall / result. drive_valid marks
//                    an autonomous step; otherwise motor fields are zero.
//   config port    : cfg_valid / cfg_ready / cfg_index / cfg_data, always
//                    ready; write only while the block is idle.
//   The item word passes the input register and then the result register
//   before result_valid rises. Throughput: 1 word per cycle while the result
//   is not stalled; echo width, reciprocal multiply for /58 and FSM all sit
//   between the input register and the result register.
//   A stalled result holds; the input register still takes one more word and
//   then item_stall rises until the result drains.
//   Reset: FSM forward, dwell start 0, all echo state and ranges 0, config
//   to its defaults, both channels empty.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_avoid_fsm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  uoa_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output uoa_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uoa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uoa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic                 auto_en_reg;
    uoa_pkg::nav_cfg_t    nav_cfg_reg;

    // input register
    uoa_pkg::item_t       item_reg;
    logic                 item_valid_reg;

    // result register
    uoa_pkg::result_t     result_reg, result_next;
    logic                 result_valid_reg;

    logic                 result_free;
    logic                 fire;
    logic                 capture_en;
    logic                 step_en;

    uoa_pkg::range_arr_t  range_cur, range_next;
    uoa_pkg::motor_cmd_t  cmd;
    uoa_pkg::nav_state_t  state_after;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_en_reg                <= uoa_pkg::RST_AUTO_EN;
            nav_cfg_reg.danger_lim     <= uoa_pkg::RST_DANGER;
            nav_cfg_reg.clear_lim      <= uoa_pkg::RST_RECOVER;
            nav_cfg_reg.side_margin    <= uoa_pkg::RST_MARGIN;
            nav_cfg_reg.action_time_ms <= uoa_pkg::RST_ACTION;
            nav_cfg_reg.fwd_spd        <= uoa_pkg::RST_BASE_SPD;
            nav_cfg_reg.spin_spd       <= uoa_pkg::RST_TURN_SPD;
            nav_cfg_reg.rev_spd        <= uoa_pkg::RST_BACK_SPD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (uoa_pkg::cfg_reg_t'(cfg_index))
                uoa_pkg::CFG_AUTO_EN:  auto_en_reg <= cfg_data[0];
                uoa_pkg::CFG_DANGER:   nav_cfg_reg.danger_lim  <= cfg_data[uoa_pkg::DIST_W-1:0];
                uoa_pkg::CFG_RECOVER:  nav_cfg_reg.clear_lim   <= cfg_data[uoa_pkg::DIST_W-1:0];
                uoa_pkg::CFG_MARGIN:   nav_cfg_reg.side_margin <= cfg_data[uoa_pkg::DIST_W-1:0];
                uoa_pkg::CFG_ACTION:
                    nav_cfg_reg.action_time_ms <= cfg_data[uoa_pkg::DWELL_W-1:0];
                uoa_pkg::CFG_BASE_SPD: nav_cfg_reg.fwd_spd  <= cfg_data[uoa_pkg::SPEED_W-1:0];
                uoa_pkg::CFG_TURN_SPD: nav_cfg_reg.spin_spd <= cfg_data[uoa_pkg::SPEED_W-1:0];
                uoa_pkg::CFG_BACK_SPD: nav_cfg_reg.rev_spd  <= cfg_data[uoa_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees when empty or being taken; the
    // held word moves on whenever it frees, and only then may a new word land.
    assign result_free = !result_valid_reg || !result_stall;
    assign fire        = item_valid_reg && result_free;
    assign item_stall  = item_valid_reg && !result_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!item_stall)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
    end

    assign capture_en = fire && (item_reg.opcode == uoa_pkg::OP_CAPTURE);
    assign step_en    = fire && (item_reg.opcode == uoa_pkg::OP_STEP) && auto_en_reg;

    uoa_echo u_echo (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture_en (capture_en),
        .channel    (item_reg.sensor_channel),
        .stamp      (item_reg.capture_stamp),
        .range_cur  (range_cur),
        .range_next (range_next)
    );

    // ranges only change on capture words, so the FSM sees the stored values
    uoa_nav u_nav (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .now_ms      (item_reg.now_ms),
        .ranges      (range_cur),
        .cfg         (nav_cfg_reg),
        .cmd         (cmd),
        .state_after (state_after)
    );

    always_comb
    begin
        result_next.drive_valid   = step_en;
        result_next.nav_state_out = state_after;
        result_next.motor_a_speed = cmd.a_speed;
        result_next.motor_a_dir   = cmd.a_dir;
        result_next.motor_b_speed = cmd.b_speed;
        result_next.motor_b_dir   = cmd.b_dir;
        result_next.front_range   = range_next[0];
        result_next.left_range    = range_next[1];
        result_next.right_range   = range_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_free)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a word that did not drive the motors carries stopped, zero-speed commands
    a_idle_motors: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.drive_valid) |->
            (result.motor_a_speed == '0 && result.motor_b_speed == '0 &&
             result.motor_a_dir == uoa_pkg::DIR_HALT &&
             result.motor_b_dir == uoa_pkg::DIR_HALT))
        else $error("non-driving result carries motor commands");

    // driving words only come from autonomous mode
    a_drive_auto: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.drive_valid) |-> auto_en_reg)
        else $error("drive result while autonomous mode is off");

    // input is held off only while a word waits in the input register
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_valid_reg && result_valid_reg))
        else $error("item stall with nothing buffered");

    // both motors share one speed in every drive command
    a_same_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.drive_valid) |->
            (result.motor_a_speed == result.motor_b_speed))
        else $error("motor speeds differ");

endmodule
